// File: hw/rtl/lbbf_pkg.sv
// Shared constants, codes and types of the LED bar blink and fade controller.
package lbbf_pkg;

    // Field widths and limits
    localparam int FILL_MAX   = 64;
    localparam int FILL_W     = 7;
    localparam int LEVEL_MAX  = 15;
    localparam int LEVEL_W    = 4;
    localparam int CMD_W      = 3;
    localparam int DELTA_W    = 8;
    localparam int FSUM_W     = DELTA_W + 1;
    localparam int MASK_W     = 64;
    localparam int CFG_TICK_W = 16;
    localparam int MODE_W     = 2;

    // Interpolation divider widths: quotient never exceeds the level span
    localparam int PROD_W = CFG_TICK_W + LEVEL_W;
    localparam int NUM_W  = PROD_W + 2;
    localparam int DEN_W  = CFG_TICK_W + 1;
    localparam int QUOT_W = LEVEL_W;
    localparam int QCNT_W = $clog2(QUOT_W);

    // Configuration port
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // Register reset values
    localparam logic [CFG_TICK_W-1:0] BLINK_ON_RST  = 16'd500;
    localparam logic [CFG_TICK_W-1:0] BLINK_OFF_RST = 16'd500;
    localparam logic [LEVEL_W-1:0]    FADE_START_RST = 4'd0;
    localparam logic [LEVEL_W-1:0]    FADE_END_RST   = 4'd15;
    localparam logic [CFG_TICK_W-1:0] FADE_TICKS_RST = 16'd1000;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK,
        CMD_ON,
        CMD_OFF,
        CMD_BLINK,
        CMD_FADE,
        CMD_STOP_FADE,
        CMD_ADD_FILL,
        CMD_SET_LEVEL
    } cmd_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOOP,
        MODE_PING_PONG,
        MODE_ONCE_ON,
        MODE_ONCE_OFF
    } fade_mode_t;

    typedef enum logic [2:0] {
        REG_BLINK_ON,
        REG_BLINK_OFF,
        REG_FADE_START,
        REG_FADE_END,
        REG_FADE_TICKS,
        REG_FADE_MODE
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_EVAL,
        S_DSTART,
        S_DWAIT,
        S_APPLY,
        S_DONE
    } state_t;

endpackage

// File: hw/rtl/lbbf_in_if.sv
// Command channel: valid/ready handshake with the command item.
interface lbbf_in_if
    import lbbf_pkg::*;
;
    logic                      valid;
    logic                      ready;
    cmd_t                      cmd;
    logic signed [DELTA_W-1:0] fill_delta;
    logic [LEVEL_W-1:0]        level;

    modport source (output valid, output cmd, output fill_delta, output level, input ready);
    modport sink   (input valid, input cmd, input fill_delta, input level, output ready);
endinterface

// File: hw/rtl/lbbf_out_if.sv
// Result channel: valid/ready handshake with the pixel mask and status item.
interface lbbf_out_if
    import lbbf_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [MASK_W-1:0]  pixel_mask;
    logic [LEVEL_W-1:0] brightness;
    logic               display_on;
    logic               blink_active;
    logic               fade_active;
    logic               bar_full;
    logic               bar_empty;

    modport source (output valid, output pixel_mask, output brightness, output display_on,
                    output blink_active, output fade_active, output bar_full,
                    output bar_empty, input ready);
    modport sink   (input valid, input pixel_mask, input brightness, input display_on,
                    input blink_active, input fade_active, input bar_full,
                    input bar_empty, output ready);
endinterface

// File: hw/rtl/led_bar_blink_fade_controller_top.sv
// Top level of the LED bar blink and fade controller.
//
//  channel  kind        accepted when                  carries
//  in_ch    valid/ready valid & ready at clk rise      cmd, fill_delta, level
//  out_ch   valid/ready valid & ready at clk rise      pixel_mask, brightness, flags
//  apb      write/read  writes on psel & penable & pwrite  six config registers, 4*i
//
//  A tick or start fade that interpolates steps through exec, eval, divider start, the
//  four-step divider and apply; a tick that ends a fade pass goes through exec and eval;
//  any other command goes from exec straight to done, where the result is registered. Ready
//  rises in the same cycle as the registered result. A result stalled by out_ch.ready holds the next one.
//  rst_n asynchronously resets the control, bar and config state and loads the register reset values.
module led_bar_blink_fade_controller_top
    import lbbf_pkg::*;
#(
    parameter int TICK_BITS = 16
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    lbbf_in_if.sink           in_ch,
    lbbf_out_if.source        out_ch
);

    localparam int EW = (TICK_BITS > CFG_TICK_W) ? TICK_BITS : CFG_TICK_W;

    // Configuration registers
    logic [CFG_TICK_W-1:0] blink_on_ticks_reg;
    logic [CFG_TICK_W-1:0] blink_off_ticks_reg;
    logic [LEVEL_W-1:0]    fade_start_reg;
    logic [LEVEL_W-1:0]    fade_end_reg;
    logic [CFG_TICK_W-1:0] fade_ticks_reg;
    fade_mode_t            fade_mode_reg;
    logic                  cfg_wr;
    reg_idx_t              cfg_idx;

    // Sequencer and latched item
    state_t                    state_reg, state_next;
    cmd_t                      cmd_reg;
    logic signed [DELTA_W-1:0] delta_reg;
    logic [LEVEL_W-1:0]        lvl_in_reg;
    logic                      in_acc;
    logic                      div_start;
    logic                      out_load;

    // Bar state
    logic [FILL_W-1:0]    fill_reg,     fill_next;
    logic [LEVEL_W-1:0]   level_reg,    level_next;
    logic                 lit_reg,      lit_next;
    logic                 blink_on_reg, blink_on_next;
    logic                 fade_on_reg,  fade_on_next;
    logic [TICK_BITS-1:0] blink_el_reg, blink_el_next;
    logic [TICK_BITS-1:0] fade_el_reg,  fade_el_next;
    logic [LEVEL_W-1:0]   from_reg,     from_next;
    logic [LEVEL_W-1:0]   to_reg,       to_next;
    logic [PROD_W-1:0]    prod_reg;

    // Datapath helpers
    logic [TICK_BITS-1:0]    blink_el_inc;
    logic [TICK_BITS-1:0]    fade_el_inc;
    logic                    blink_ge_on;
    logic                    blink_ge_off;
    logic [CFG_TICK_W-1:0]   dur;
    logic [EW-1:0]           fade_el_w;
    logic                    in_range;
    logic                    up;
    logic [LEVEL_W-1:0]      span;
    logic [NUM_W-1:0]        div_num;
    logic [DEN_W-1:0]        div_den;
    logic                    div_done;
    logic [QUOT_W-1:0]       div_quot;
    logic [LEVEL_W-1:0]      lvl_fade;
    logic signed [FSUM_W-1:0] fsum;
    logic [FILL_W-1:0]       fill_sat;
    logic [LEVEL_W-1:0]      start_clamp;
    logic [LEVEL_W-1:0]      end_clamp;
    logic [LEVEL_W-1:0]      lvl_in_clamp;

    // Result register
    logic                 out_valid_reg;
    logic [MASK_W-1:0]    mask_reg;
    logic [LEVEL_W-1:0]   bright_reg;
    logic                 disp_reg;
    logic                 blink_act_reg;
    logic                 fade_act_reg;
    logic                 full_reg;
    logic                 empty_reg;

    // ---------------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_on_ticks_reg  <= BLINK_ON_RST;
            blink_off_ticks_reg <= BLINK_OFF_RST;
            fade_start_reg      <= FADE_START_RST;
            fade_end_reg        <= FADE_END_RST;
            fade_ticks_reg      <= FADE_TICKS_RST;
            fade_mode_reg       <= MODE_PING_PONG;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_BLINK_ON:   blink_on_ticks_reg  <= pwdata[CFG_TICK_W-1:0];
                REG_BLINK_OFF:  blink_off_ticks_reg <= pwdata[CFG_TICK_W-1:0];
                REG_FADE_START: fade_start_reg      <= pwdata[LEVEL_W-1:0];
                REG_FADE_END:   fade_end_reg        <= pwdata[LEVEL_W-1:0];
                REG_FADE_TICKS: fade_ticks_reg      <= pwdata[CFG_TICK_W-1:0];
                REG_FADE_MODE:  fade_mode_reg       <= fade_mode_t'(pwdata[MODE_W-1:0]);
                default:        ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (cfg_idx)
            REG_BLINK_ON:   prdata = APB_DW'(blink_on_ticks_reg);
            REG_BLINK_OFF:  prdata = APB_DW'(blink_off_ticks_reg);
            REG_FADE_START: prdata = APB_DW'(fade_start_reg);
            REG_FADE_END:   prdata = APB_DW'(fade_end_reg);
            REG_FADE_TICKS: prdata = APB_DW'(fade_ticks_reg);
            REG_FADE_MODE:  prdata = APB_DW'(fade_mode_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    assign in_acc = in_ch.valid & in_ch.ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if ((cmd_reg == CMD_TICK && fade_on_reg) || cmd_reg == CMD_FADE)
                begin
                    state_next = S_EVAL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_EVAL:   state_next = in_range ? S_DSTART : S_DONE;
            S_DSTART: state_next = S_DWAIT;
            S_DWAIT:
            begin
                if (div_done)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:  state_next = S_DONE;
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ch.ready = (state_reg == S_IDLE);
        div_start   = (state_reg == S_DSTART);
        out_load    = (state_reg == S_DONE) && (!out_valid_reg || out_ch.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Latch the accepted item
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg    <= in_ch.cmd;
            delta_reg  <= in_ch.fill_delta;
            lvl_in_reg <= in_ch.level;
        end
    end

    // ---------------------------------------------------------------------
    // Datapath
    // ---------------------------------------------------------------------
    // Saturating tick counters
    assign blink_el_inc = (blink_el_reg == {TICK_BITS{1'b1}}) ? blink_el_reg
                                                               : blink_el_reg + 1'b1;
    assign fade_el_inc  = (fade_el_reg == {TICK_BITS{1'b1}}) ? fade_el_reg
                                                              : fade_el_reg + 1'b1;
    assign blink_ge_on  = EW'(blink_el_inc) >= EW'(blink_on_ticks_reg);
    assign blink_ge_off = EW'(blink_el_inc) >= EW'(blink_off_ticks_reg);

    // Fade pass length and position; a zero length counts as one tick
    assign dur       = (fade_ticks_reg == '0) ? CFG_TICK_W'(1) : fade_ticks_reg;
    assign fade_el_w = EW'(fade_el_reg);
    assign in_range  = fade_el_w < EW'(dur);
    assign up        = to_reg >= from_reg;
    assign span      = up ? (to_reg - from_reg) : (from_reg - to_reg);

    // Round half away from zero: (2n + d) / 2d
    assign div_num  = NUM_W'({prod_reg, 1'b0}) + NUM_W'(dur);
    assign div_den  = {dur, 1'b0};
    assign lvl_fade = up ? (from_reg + div_quot) : (from_reg - div_quot);

    // Saturating fill add
    assign fsum     = $signed({2'b00, fill_reg}) + $signed({delta_reg[DELTA_W-1], delta_reg});
    assign fill_sat = fsum[FSUM_W-1] ? '0 :
                      (fsum > $signed(FSUM_W'(FILL_MAX))) ? FILL_W'(FILL_MAX) :
                      fsum[FILL_W-1:0];

    // Clamp levels to the maximum brightness
    assign start_clamp  = (fade_start_reg > LEVEL_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX)
                                                                 : fade_start_reg;
    assign end_clamp    = (fade_end_reg > LEVEL_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX)
                                                               : fade_end_reg;
    assign lvl_in_clamp = (lvl_in_reg > LEVEL_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX)
                                                             : lvl_in_reg;

    lbbf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Apply the command, the fade step and the end of a pass
    always_comb
    begin
        fill_next     = fill_reg;
        level_next    = level_reg;
        lit_next      = lit_reg;
        blink_on_next = blink_on_reg;
        fade_on_next  = fade_on_reg;
        blink_el_next = blink_el_reg;
        fade_el_next  = fade_el_reg;
        from_next     = from_reg;
        to_next       = to_reg;
        unique case (state_reg)
            S_EXEC:
            begin
                unique case (cmd_reg)
                    CMD_TICK:
                    begin
                        if (blink_on_reg)
                        begin
                            blink_el_next = blink_el_inc;
                            if (lit_reg && blink_ge_on)
                            begin
                                lit_next      = 1'b0;
                                blink_el_next = '0;
                            end
                            else if (!lit_reg && blink_ge_off)
                            begin
                                lit_next      = 1'b1;
                                blink_el_next = '0;
                            end
                        end
                        if (fade_on_reg)
                        begin
                            fade_el_next = fade_el_inc;
                        end
                    end
                    CMD_ON:
                    begin
                        blink_on_next = 1'b0;
                        fade_on_next  = 1'b0;
                        lit_next      = 1'b1;
                    end
                    CMD_OFF:
                    begin
                        blink_on_next = 1'b0;
                        fade_on_next  = 1'b0;
                        lit_next      = 1'b0;
                    end
                    CMD_BLINK:
                    begin
                        blink_on_next = 1'b1;
                        lit_next      = 1'b1;
                        blink_el_next = '0;
                    end
                    CMD_FADE:
                    begin
                        fade_on_next = 1'b1;
                        from_next    = start_clamp;
                        to_next      = end_clamp;
                        level_next   = start_clamp;
                        fade_el_next = '0;
                    end
                    CMD_STOP_FADE: fade_on_next = 1'b0;
                    CMD_ADD_FILL:  fill_next    = fill_sat;
                    CMD_SET_LEVEL: level_next   = lvl_in_clamp;
                    default:       ;
                endcase
            end
            S_EVAL:
            begin
                // End of pass: the mode decides
                if (!in_range)
                begin
                    unique case (fade_mode_reg)
                        MODE_LOOP:
                        begin
                            fade_el_next = '0;
                            level_next   = from_reg;
                            if (!blink_on_reg)
                            begin
                                lit_next = 1'b1;
                            end
                        end
                        MODE_PING_PONG:
                        begin
                            from_next    = to_reg;
                            to_next      = from_reg;
                            fade_el_next = '0;
                            level_next   = to_reg;
                            if (!blink_on_reg)
                            begin
                                lit_next = 1'b1;
                            end
                        end
                        MODE_ONCE_ON:  fade_on_next = 1'b0;
                        MODE_ONCE_OFF:
                        begin
                            blink_on_next = 1'b0;
                            fade_on_next  = 1'b0;
                            lit_next      = 1'b0;
                        end
                        default:       ;
                    endcase
                end
            end
            S_APPLY:
            begin
                level_next = lvl_fade;
                if (!blink_on_reg)
                begin
                    lit_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Hold bar state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= FILL_W'(FILL_MAX);
            level_reg    <= LEVEL_W'(LEVEL_MAX);
            lit_reg      <= 1'b0;
            blink_on_reg <= 1'b0;
            fade_on_reg  <= 1'b0;
            blink_el_reg <= '0;
            fade_el_reg  <= '0;
            from_reg     <= '0;
            to_reg       <= '0;
        end
        else
        begin
            fill_reg     <= fill_next;
            level_reg    <= level_next;
            lit_reg      <= lit_next;
            blink_on_reg <= blink_on_next;
            fade_on_reg  <= fade_on_next;
            blink_el_reg <= blink_el_next;
            fade_el_reg  <= fade_el_next;
            from_reg     <= from_next;
            to_reg       <= to_next;
        end
    end

    // Register the interpolation product ahead of the divider
    always_ff @(posedge clk)
    begin
        if (state_reg == S_EVAL)
        begin
            prod_reg <= PROD_W'(fade_el_w[CFG_TICK_W-1:0]) * PROD_W'(span);
        end
    end

    // ---------------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Build the thermometer mask and flags
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            mask_reg      <= (lit_reg && level_reg != '0)
                             ? ~({MASK_W{1'b1}} << fill_reg) : '0;
            bright_reg    <= level_reg;
            disp_reg      <= lit_reg;
            blink_act_reg <= blink_on_reg;
            fade_act_reg  <= fade_on_reg;
            full_reg      <= (fill_reg == FILL_W'(FILL_MAX));
            empty_reg     <= (fill_reg == '0);
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.pixel_mask   = mask_reg;
    assign out_ch.brightness   = bright_reg;
    assign out_ch.display_on   = disp_reg;
    assign out_ch.blink_active = blink_act_reg;
    assign out_ch.fade_active  = fade_act_reg;
    assign out_ch.bar_full     = full_reg;
    assign out_ch.bar_empty    = empty_reg;

endmodule

// File: hw/rtl/lbbf_div.sv
// Restoring divider for the fade interpolation, one quotient bit per cycle.
module lbbf_div
    import lbbf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output logic              done,
    output logic [QUOT_W-1:0] quot
);

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [QCNT_W-1:0] cnt_reg,   cnt_next;
    logic [NUM_W-1:0]  rem_reg,   rem_next;
    logic [DEN_W-1:0]  den_reg,   den_next;
    logic [QUOT_W-1:0] quot_reg,  quot_next;
    logic [NUM_W-1:0]  den_sh;
    logic              fits;

    // Shared compare and subtract: divisor aligned to the current quotient bit
    assign den_sh = NUM_W'(den_reg) << cnt_reg;
    assign fits   = rem_reg >= den_sh;

    // Step the division
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = QCNT_W'(QUOT_W - 1);
            rem_next  = num;
            den_next  = den;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - den_sh;
            end
            quot_next = {quot_reg[QUOT_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold operands and partial quotient
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// File: hw/rtl/lbbf_chk.sv
// Port-level checker for the LED bar controller and its bind to the top level.
module lbbf_chk
    import lbbf_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [MASK_W-1:0]  pixel_mask,
    input logic [LEVEL_W-1:0] brightness,
    input logic               display_on,
    input logic               bar_full,
    input logic               bar_empty
);

    // One item at a time: after acceptance the block is busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after an item was accepted");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_mask) && $stable(brightness)
                                    && $stable(display_on))
        else $error("stalled result changed");

    // Full and empty exclude each other
    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(bar_full && bar_empty))
        else $error("bar reported full and empty");

    // Lit pixels need a shown bar with nonzero brightness
    a_mask_dark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pixel_mask != '0 |-> display_on && brightness != '0)
        else $error("pixels lit while bar dark");

    // A full shown bar lights every pixel
    a_mask_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && display_on && brightness != '0 && bar_full |-> pixel_mask == '1)
        else $error("full bar not fully lit");

endmodule

bind led_bar_blink_fade_controller_top lbbf_chk u_lbbf_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .pixel_mask (out_ch.pixel_mask),
    .brightness (out_ch.brightness),
    .display_on (out_ch.display_on),
    .bar_full   (out_ch.bar_full),
    .bar_empty  (out_ch.bar_empty)
);
